FILE: rtl/dsm_pkg.sv
// Shared types, constants and elaboration-time table functions of the disk-square map.
package dsm_pkg;

  localparam int COORD_FRAC_BITS_DFLT = 14;
  localparam int CORDIC_STEPS_DFLT = 16;
  localparam int WORK_FRAC = 30;
  localparam int TAB_LEN = 32;
  localparam int DIV_STEPS = WORK_FRAC + 1;
  localparam int LANE_W = 36;

  localparam logic signed [LANE_W-1:0] ANG_Q = 36'sd1 <<< WORK_FRAC;
  localparam logic signed [LANE_W-1:0] ANG_Q2 = ANG_Q * 2;
  localparam logic signed [LANE_W-1:0] ANG_Q3 = ANG_Q * 3;
  localparam logic signed [LANE_W-1:0] ANG_Q4 = ANG_Q * 4;
  localparam logic signed [LANE_W-1:0] ANG_Q5 = ANG_Q * 5;
  localparam logic signed [LANE_W-1:0] ANG_Q6 = ANG_Q * 6;
  localparam logic signed [LANE_W-1:0] ANG_Q8 = ANG_Q * 8;

  typedef enum logic [1:0] {
    SECT_RIGHT,
    SECT_TOP,
    SECT_LEFT,
    SECT_BOTTOM
  } sect_t;

  typedef struct packed {
    logic                     big_x;
    logic                     neg;
    logic                     zero;
    sect_t                    sector;
    logic signed [LANE_W-1:0] cx;
    logic signed [LANE_W-1:0] cy;
    logic signed [LANE_W-1:0] z;
    logic [32:0]              rem;
    logic [31:0]              den;
    logic [30:0]              quo;
    logic signed [71:0]       prod;
  } lane_t;

  // Unsigned quotient by shift and subtract, for divisors below 2^63.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'h1;
      end
    end
    return q;
  endfunction

  // Pi/4 in Q62 from Machin's formula, summed as alternating series.
  function automatic longint unsigned pi4_q62();
    longint unsigned p;
    longint unsigned s;
    longint unsigned t;
    longint unsigned acc;
    longint unsigned k;
    bit neg;
    s = 0;
    k = 0;
    neg = 1'b0;
    p = udiv64(64'h1 << 62, 64'd5);
    while (p != 0) begin
      t = udiv64(p, 2 * k + 1);
      s = neg ? s - t : s + t;
      neg = !neg;
      p = udiv64(p, 64'd25);
      k = k + 1;
    end
    acc = 4 * s;
    s = 0;
    k = 0;
    neg = 1'b0;
    p = udiv64(64'h1 << 62, 64'd239);
    while (p != 0) begin
      t = udiv64(p, 2 * k + 1);
      s = neg ? s - t : s + t;
      neg = !neg;
      p = udiv64(p, 64'd57121);
      k = k + 1;
    end
    return acc - s;
  endfunction

  // Arctangent of 2^-i in Q62.
  function automatic longint unsigned atan_pow2_q62(int i);
    longint unsigned s;
    longint unsigned t;
    longint unsigned k;
    int e;
    bit neg;
    s = 0;
    k = 0;
    neg = 1'b0;
    e = 62 - i;
    while (e >= 0) begin
      t = udiv64(64'h1 << e, 2 * k + 1);
      s = neg ? s - t : s + t;
      neg = !neg;
      k = k + 1;
      e = 62 - i * int'(2 * k + 1);
    end
    return s;
  endfunction

  // Arctangent of 2^-i in units of pi/4, Q30, rounded.
  function automatic longint unsigned atan_q30(int i);
    longint unsigned pi4;
    longint unsigned rem;
    longint unsigned q;
    if (i == 0) begin
      return 64'h1 << WORK_FRAC;
    end
    pi4 = pi4_q62();
    rem = atan_pow2_q62(i);
    q = 0;
    for (int n = 0; n < WORK_FRAC + 1; n++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= pi4) begin
        rem = rem - pi4;
        q = q | 64'h1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  // Inverse CORDIC gain over n steps, Q30, rounded.
  function automatic longint unsigned inv_gain_q30(int n);
    longint unsigned p;
    longint unsigned r;
    longint unsigned bt;
    p = 64'h1 << 60;
    r = 0;
    bt = 64'h1 << 62;
    for (int i = 0; i < n && i < TAB_LEN; i++) begin
      p = p + (p >> (2 * i));
    end
    while (bt > p) begin
      bt = bt >> 2;
    end
    while (bt != 0) begin
      if (p >= r + bt) begin
        p = p - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return udiv64((64'h1 << 60) + (r >> 1), r);
  endfunction

endpackage

FILE: rtl/dsm_in_if.sv
// Input channel carrying one point to be mapped.
interface dsm_in_if #(
  parameter int WIDTH = dsm_pkg::COORD_FRAC_BITS_DFLT + 2
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] coord_a_in;
  logic signed [WIDTH-1:0] coord_b_in;

  modport source (output valid, output coord_a_in, output coord_b_in, input ready);
  modport sink (input valid, input coord_a_in, input coord_b_in, output ready);
endinterface

FILE: rtl/dsm_out_if.sv
// Output channel carrying one mapped point.
interface dsm_out_if #(
  parameter int WIDTH = dsm_pkg::COORD_FRAC_BITS_DFLT + 2
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] coord_a_out;
  logic signed [WIDTH-1:0] coord_b_out;

  modport source (output valid, output coord_a_out, output coord_b_out, input ready);
  modport sink (input valid, input coord_a_out, input coord_b_out, output ready);
endinterface

FILE: rtl/disk_square_concentric_map.sv
// Pipelined concentric map between the unit square and the unit disk.
//
//   channel  | kind        | payload
//   ---------+-------------+--------------------------------------
//   point    | valid/ready | coord_a_in, coord_b_in (signed Q1.F)
//   mapped   | valid/ready | coord_a_out, coord_b_out (signed Q1.F)
//   cfg      | write only  | cfg_wdata -> direction
//
// One transaction enters per cycle while the output is not stalled; the depth is set by
// the 31-step divider pipeline, the CORDIC stages and the multiply stages.
// Reset clears the valid bits and the direction register to square-to-disk.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
module disk_square_concentric_map #(
  parameter int COORD_FRAC_BITS = dsm_pkg::COORD_FRAC_BITS_DFLT,
  parameter int CORDIC_STEPS = dsm_pkg::CORDIC_STEPS_DFLT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_wdata,
  dsm_in_if.sink       point,
  dsm_out_if.source    mapped
);

  localparam int CW = COORD_FRAC_BITS + 2;
  localparam int SH = dsm_pkg::WORK_FRAC - COORD_FRAC_BITS;
  localparam int NS = (CORDIC_STEPS > dsm_pkg::TAB_LEN) ? dsm_pkg::TAB_LEN : CORDIC_STEPS;
  localparam int ST_DIV0 = 1;
  localparam int ST_A = ST_DIV0 + dsm_pkg::DIV_STEPS;
  localparam int ST_B = ST_A + 1;
  localparam int ST_C0 = ST_B + 1;
  localparam int ST_M1 = ST_C0 + NS;
  localparam int ST_M2 = ST_M1 + 1;
  localparam int ST_M3 = ST_M2 + 1;
  localparam int ST_M4 = ST_M3 + 1;
  localparam int L = ST_M4 + 1;

  localparam logic signed [31:0] INV_S = 32'(dsm_pkg::inv_gain_q30(NS));
  localparam logic signed [71:0] RND30 = 72'sd1 <<< (dsm_pkg::WORK_FRAC - 1);
  localparam logic signed [35:0] HALF = (36'sd1 <<< SH) >>> 1;
  localparam logic signed [35:0] ONE = 36'sd1 <<< COORD_FRAC_BITS;

  logic                direction;
  logic [L-1:0]        vld;
  dsm_pkg::lane_t      pipe [L];
  logic                adv;
  logic                out_vld;
  logic signed [CW-1:0] out_a;
  logic signed [CW-1:0] out_b;

  function automatic logic signed [CW-1:0] narrow(logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + HALF) >>> SH;
    if (t > ONE) begin
      t = ONE;
    end else if (t < -ONE) begin
      t = -ONE;
    end
    return t[CW-1:0];
  endfunction

  assign adv = !out_vld || mapped.ready;
  assign point.ready = adv;
  assign mapped.valid = out_vld;
  assign mapped.coord_a_out = out_a;
  assign mapped.coord_b_out = out_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_we) begin
      direction <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld <= {vld[L-2:0], point.valid};
      out_vld <= vld[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_a <= narrow(pipe[L-1].cx);
      out_b <= narrow(pipe[L-1].cy);
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_stage
    dsm_pkg::lane_t nxt;

    if (k == 0) begin : g_prep
      always_comb begin
        logic signed [35:0] a_w;
        logic signed [35:0] b_w;
        logic [31:0]        ax;
        logic [31:0]        ay;
        a_w = 36'(point.coord_a_in) <<< SH;
        b_w = 36'(point.coord_b_in) <<< SH;
        ax = a_w[35] ? 32'(-a_w) : 32'(a_w);
        ay = b_w[35] ? 32'(-b_w) : 32'(b_w);
        nxt = '0;
        nxt.cx = a_w;
        nxt.cy = b_w;
        nxt.big_x = ax > ay;
        nxt.neg = a_w[35] ^ b_w[35];
        nxt.rem = {1'b0, (ax > ay) ? ay : ax};
        nxt.den = (ax > ay) ? ax : ay;
        nxt.zero = ((ax > ay) ? ax : ay) == 32'd0;
      end
    end else if (k < ST_A) begin : g_div
      always_comb begin
        logic [32:0] trial;
        logic        ge;
        nxt = pipe[k-1];
        trial = (k == ST_DIV0) ? pipe[k-1].rem : {pipe[k-1].rem[31:0], 1'b0};
        ge = trial >= {1'b0, pipe[k-1].den};
        nxt.rem = ge ? trial - {1'b0, pipe[k-1].den} : trial;
        nxt.quo = {pipe[k-1].quo[29:0], ge};
      end
    end else if (k == ST_A) begin : g_angle
      always_comb begin
        dsm_pkg::lane_t     p;
        logic signed [35:0] sq;
        logic signed [32:0] r;
        p = pipe[k-1];
        nxt = p;
        sq = 36'(p.quo);
        if (p.neg) begin
          sq = -sq;
        end
        r = p.big_x ? p.cx[32:0] : p.cy[32:0];
        if (direction) begin
          if (p.cx[35]) begin
            if (!p.cy[35]) begin
              nxt.cx = p.cy;
              nxt.cy = -p.cx;
              nxt.z = dsm_pkg::ANG_Q2;
            end else begin
              nxt.cx = -p.cy;
              nxt.cy = p.cx;
              nxt.z = -dsm_pkg::ANG_Q2;
            end
          end else begin
            nxt.z = '0;
          end
        end else begin
          if (p.big_x) begin
            nxt.z = sq;
          end else if (p.zero) begin
            nxt.z = '0;
          end else begin
            nxt.z = dsm_pkg::ANG_Q2 - sq;
          end
          nxt.prod = r * INV_S;
        end
      end
    end else if (k == ST_B) begin : g_seed
      always_comb begin
        dsm_pkg::lane_t     p;
        logic signed [35:0] kr;
        p = pipe[k-1];
        nxt = p;
        kr = 36'((p.prod + RND30) >>> dsm_pkg::WORK_FRAC);
        if (!direction) begin
          if (p.z > dsm_pkg::ANG_Q) begin
            nxt.cx = '0;
            nxt.cy = kr;
            nxt.z = p.z - dsm_pkg::ANG_Q2;
          end else begin
            nxt.cx = kr;
            nxt.cy = '0;
          end
        end
      end
    end else if (k < ST_M1) begin : g_cordic
      localparam int CI = k - ST_C0;
      localparam logic signed [35:0] ATAN = 36'(dsm_pkg::atan_q30(CI));
      always_comb begin
        dsm_pkg::lane_t     p;
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        p = pipe[k-1];
        nxt = p;
        xs = p.cx >>> CI;
        ys = p.cy >>> CI;
        if (direction) begin
          if (!p.cy[35]) begin
            nxt.cx = p.cx + ys;
            nxt.cy = p.cy - xs;
            nxt.z = p.z + ATAN;
          end else begin
            nxt.cx = p.cx - ys;
            nxt.cy = p.cy + xs;
            nxt.z = p.z - ATAN;
          end
        end else begin
          if (!p.z[35]) begin
            nxt.cx = p.cx - ys;
            nxt.cy = p.cy + xs;
            nxt.z = p.z - ATAN;
          end else begin
            nxt.cx = p.cx + ys;
            nxt.cy = p.cy - xs;
            nxt.z = p.z + ATAN;
          end
        end
      end
    end else if (k == ST_M1) begin : g_radius_mul
      always_comb begin
        dsm_pkg::lane_t     p;
        logic signed [33:0] m;
        p = pipe[k-1];
        nxt = p;
        m = p.cx[33:0];
        if (direction) begin
          nxt.prod = m * INV_S;
          if (p.z < -dsm_pkg::ANG_Q) begin
            nxt.z = p.z + dsm_pkg::ANG_Q8;
          end
        end
      end
    end else if (k == ST_M2) begin : g_sector
      always_comb begin
        dsm_pkg::lane_t p;
        p = pipe[k-1];
        nxt = p;
        if (direction) begin
          nxt.cx = 36'((p.prod + RND30) >>> dsm_pkg::WORK_FRAC);
          priority if (p.z < dsm_pkg::ANG_Q) begin
            nxt.sector = dsm_pkg::SECT_RIGHT;
            nxt.z = p.z;
          end else if (p.z < dsm_pkg::ANG_Q3) begin
            nxt.sector = dsm_pkg::SECT_TOP;
            nxt.z = dsm_pkg::ANG_Q2 - p.z;
          end else if (p.z < dsm_pkg::ANG_Q5) begin
            nxt.sector = dsm_pkg::SECT_LEFT;
            nxt.z = dsm_pkg::ANG_Q4 - p.z;
          end else begin
            nxt.sector = dsm_pkg::SECT_BOTTOM;
            nxt.z = p.z - dsm_pkg::ANG_Q6;
          end
        end
      end
    end else if (k == ST_M3) begin : g_offset_mul
      always_comb begin
        dsm_pkg::lane_t     p;
        logic signed [32:0] off;
        logic signed [33:0] r;
        p = pipe[k-1];
        nxt = p;
        off = p.z[32:0];
        r = p.cx[33:0];
        if (direction) begin
          nxt.prod = off * r;
        end
      end
    end else begin : g_place
      always_comb begin
        dsm_pkg::lane_t     p;
        logic signed [35:0] t;
        p = pipe[k-1];
        nxt = p;
        t = 36'((p.prod + RND30) >>> dsm_pkg::WORK_FRAC);
        if (direction) begin
          unique case (p.sector)
            dsm_pkg::SECT_RIGHT: begin
              nxt.cx = p.cx;
              nxt.cy = t;
            end
            dsm_pkg::SECT_TOP: begin
              nxt.cx = t;
              nxt.cy = p.cx;
            end
            dsm_pkg::SECT_LEFT: begin
              nxt.cx = -p.cx;
              nxt.cy = t;
            end
            dsm_pkg::SECT_BOTTOM: begin
              nxt.cx = t;
              nxt.cy = -p.cx;
            end
            default: begin
              nxt.cx = p.cx;
              nxt.cy = t;
            end
          endcase
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= nxt;
      end
    end
  end

endmodule

FILE: rtl/dsm_checker.sv
// Port-level checks for the disk-square map, bound to the top level.
module dsm_checker #(
  parameter int COORD_FRAC_BITS = dsm_pkg::COORD_FRAC_BITS_DFLT
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [COORD_FRAC_BITS+1:0] coord_a_out,
  input logic signed [COORD_FRAC_BITS+1:0] coord_b_out
);

  localparam logic signed [COORD_FRAC_BITS+1:0] ONE =
    (COORD_FRAC_BITS + 2)'(1) <<< COORD_FRAC_BITS;

  // The pipeline moves exactly when the output register is empty or drained.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not match the output register state");

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Every mapped coordinate is saturated to the closed unit interval.
  a_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (coord_a_out <= ONE && coord_a_out >= -ONE &&
                   coord_b_out <= ONE && coord_b_out >= -ONE))
    else $error("mapped coordinate outside plus or minus one");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(coord_a_out) && $stable(coord_b_out)))
    else $error("stalled transaction changed or vanished");

endmodule

bind disk_square_concentric_map dsm_checker #(
  .COORD_FRAC_BITS(COORD_FRAC_BITS)
) u_dsm_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(point.ready),
  .out_valid(mapped.valid),
  .out_ready(mapped.ready),
  .coord_a_out(mapped.coord_a_out),
  .coord_b_out(mapped.coord_b_out)
);
